[rtl/uccp_pkg.sv]
package uccp_pkg;

	localparam int LineMaxDef = 21;

	localparam logic [1:0] EchoNone  = 2'd0;
	localparam logic [1:0] EchoChar  = 2'd1;
	localparam logic [1:0] EchoErase = 2'd2;

	localparam logic [2:0] StNone    = 3'd0;
	localparam logic [2:0] StShow    = 3'd1;
	localparam logic [2:0] StAddr    = 3'd2;
	localparam logic [2:0] StRtu     = 3'd3;
	localparam logic [2:0] StMode    = 3'd4;
	localparam logic [2:0] StInvalid = 3'd5;
	localparam logic [2:0] StSame    = 3'd6;

	localparam logic [1:0] TgtIp   = 2'd0;
	localparam logic [1:0] TgtSub  = 2'd1;
	localparam logic [1:0] TgtGate = 2'd2;
	localparam logic [1:0] TgtMac  = 2'd3;

	localparam logic [0:0] RegBackspace = 1'b0;
	localparam logic [0:0] RegEnter     = 1'b1;

	// Work passed from the line editor to the evaluator.
	typedef struct packed {
		logic       eval;
		logic [1:0] kind;
		logic [7:0] echo;
	} job_t;

	function automatic logic is_digit(input logic [7:0] c);
		return c >= 8'h30 && c <= 8'h39;
	endfunction

	function automatic logic is_print(input logic [7:0] c);
		return is_digit(c) || (c >= 8'h61 && c <= 8'h7a) || (c >= 8'h41 && c <= 8'h5a)
			|| c == 8'h20 || c == 8'h2e || c == 8'h3f || c == 8'h3d;
	endfunction

endpackage

[rtl/uccp_front.sv]
// Line editor: classifies each byte, updates the line store, issues a job.
module uccp_front #(
	parameter int LINE_MAX = uccp_pkg::LineMaxDef
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        in_valid,
	input  logic [7:0]                  in_byte,
	input  logic [7:0]                  bs_code,
	input  logic [7:0]                  en_code,
	input  logic                        busy,
	output logic                        job_valid,
	output uccp_pkg::job_t              job,
	output logic [$clog2(LINE_MAX+1)-1:0] eval_len,
	input  logic [$clog2(LINE_MAX)-1:0] rd_addr,
	output logic [7:0]                  rd_data
);
	import uccp_pkg::*;
	localparam int LW = $clog2(LINE_MAX + 1);
	localparam int AW = $clog2(LINE_MAX);

	logic [7:0]    mem [LINE_MAX];
	logic [LW-1:0] len_q;
	job_t          jb;
	logic          wr;

	always_comb begin
		jb = '0;
		wr = 1'b0;
		if (in_byte == en_code) begin
			jb.eval = len_q != '0;
		end else if (in_byte == bs_code) begin
			if (len_q != '0) jb.kind = EchoErase;
		end else if (is_print(in_byte) && len_q < LW'(LINE_MAX)) begin
			wr = 1'b1;
			jb.kind = EchoChar;
			jb.echo = in_byte;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && wr) mem[len_q[AW-1:0]] <= in_byte;
		rd_data <= mem[rd_addr];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			len_q     <= '0;
			job_valid <= 1'b0;
		end else begin
			job_valid <= in_valid;
			if (in_valid) begin
				if (jb.eval) len_q <= '0;
				else if (jb.kind == EchoErase) len_q <= len_q - 1'b1;
				else if (wr) len_q <= len_q + 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid) begin
			job      <= jb;
			eval_len <= len_q;
		end
	end

	// busy is high while the evaluator reads the store; input is held off then.
`ifndef SYNTH
	a_nowr: assert property (@(posedge clk) disable iff (!arst_n) busy |-> !in_valid)
		else $error("write while evaluating");
`endif
endmodule

[rtl/uccp_eval.sv]
// Evaluator: walks the stored line one character a cycle and forms the result.
module uccp_eval #(
	parameter int LINE_MAX = uccp_pkg::LineMaxDef
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          job_valid,
	input  uccp_pkg::job_t                job,
	input  logic [$clog2(LINE_MAX+1)-1:0] eval_len,
	output logic [$clog2(LINE_MAX)-1:0]   rd_addr,
	input  logic [7:0]                    rd_data,
	output logic                          busy,
	output logic                          res_valid,
	output logic [1:0]                    res_kind,
	output logic [7:0]                    res_echo,
	output logic [2:0]                    res_status,
	output logic [1:0]                    res_target,
	output logic [47:0]                   res_value,
	output logic [1:0]                    mode_q,
	output logic [5:0]                    rtu_q
);
	import uccp_pkg::*;
	localparam int LW = $clog2(LINE_MAX + 1);
	localparam int AW = $clog2(LINE_MAX);

	localparam logic [1:0] S_IDLE = 2'd0, S_RUN = 2'd1, S_DONE = 2'd2;

	logic [1:0]    st_q;
	logic [LW-1:0] len_q, idx_q;      // idx_q: read address presented to the line store
	logic          rvalid_q;
	logic [7:0]    c0_q, c4_q, c5_q, c6_q, c7_q, c8_q;
	// Candidate match flags, cleared as characters disagree.
	logic ip_q, sub_q, mac_q, gate_q, rtu_q2, mode_q2;
	// Dotted-quad parsers for start offsets 3, 4, 5.
	logic [2:0]  dok_q, dig_q;
	logic [1:0]  dots_q [3];
	logic [8:0]  oct_q [3];
	logic [31:0] acc_q [3];
	logic [47:0] hex_q;
	logic        hexok_q;
	logic [LW-1:0] pos;

	assign rd_addr = idx_q[AW-1:0];
	assign busy    = st_q != S_IDLE;
	assign pos     = idx_q - 1'b1;

	function automatic logic [7:0] pch(input int w, input logic [LW-1:0] p);
		case (w)
			0: return (p == 0) ? 8'h49 : (p == 1) ? 8'h50 : 8'h3d;                   // IP=
			1: return (p == 0) ? 8'h53 : (p == 1) ? 8'h55 : (p == 2) ? 8'h42 : 8'h3d; // SUB=
			2: return (p == 0) ? 8'h4d : (p == 1) ? 8'h41 : (p == 2) ? 8'h43 : 8'h3d; // MAC=
			3: return (p == 0) ? 8'h47 : (p == 1) ? 8'h41 : (p == 2) ? 8'h54
				: (p == 3) ? 8'h45 : 8'h3d;                                          // GATE=
			4: return (p == 0) ? 8'h52 : (p == 1) ? 8'h54 : (p == 2) ? 8'h55 : 8'h3d; // RTU=
			default: return (p == 0) ? 8'h4d : (p == 1) ? 8'h4f : (p == 2) ? 8'h44
				: (p == 3) ? 8'h45 : 8'h3d;                                          // MODE=
		endcase
	endfunction

	function automatic logic pfx_ok(input int w, input int n, input logic [LW-1:0] p,
			input logic [7:0] c);
		return (p >= LW'(n)) || (c == pch(w, p));
	endfunction

	logic [3:0] nib;
	always_comb begin
		nib = is_digit(rd_data) ? rd_data[3:0] : 4'(rd_data - 8'h37);
	end

	// Final decision.
	logic [2:0]  f_st;
	logic [1:0]  f_tg;
	logic [47:0] f_val;
	logic        f_setr, f_setm;
	logic [1:0]  f_mode;
	always_comb begin
		logic [2:0] okq;
		f_st = StInvalid; f_tg = TgtIp; f_val = '0;
		f_setr = 1'b0; f_setm = 1'b0; f_mode = 2'd0;
		for (int k = 0; k < 3; k++)
			okq[k] = dok_q[k] && dots_q[k] == 2'd3 && dig_q[k] && !oct_q[k][8];
		if (len_q == LW'(1) && c0_q == 8'h3f) f_st = StShow;
		else if (ip_q && len_q >= LW'(3) && okq[0]) begin
			f_st = StAddr; f_tg = TgtIp; f_val = {16'd0, acc_q[0][23:0], oct_q[0][7:0]};
		end else if (rtu_q2 && len_q == LW'(5)) begin
			if (is_digit(c4_q)) begin f_st = StRtu; f_setr = 1'b1; end
			else f_st = StSame;
		end else if (sub_q && len_q >= LW'(4) && okq[1]) begin
			f_st = StAddr; f_tg = TgtSub; f_val = {16'd0, acc_q[1][23:0], oct_q[1][7:0]};
		end else if (mac_q && len_q == LW'(16) && hexok_q) begin
			f_st = StAddr; f_tg = TgtMac; f_val = hex_q;
		end else if (gate_q && len_q >= LW'(5) && okq[2]) begin
			f_st = StAddr; f_tg = TgtGate; f_val = {16'd0, acc_q[2][23:0], oct_q[2][7:0]};
		end else if (mode_q2 && len_q >= LW'(5)) begin
			if (len_q == LW'(8) && c5_q == 8'h54 && c6_q == 8'h43 && c7_q == 8'h50) begin
				f_mode = 2'd1; f_setm = 1'b1;
			end else if (len_q == LW'(8) && c5_q == 8'h55 && c6_q == 8'h44 && c7_q == 8'h50) begin
				f_mode = 2'd0; f_setm = 1'b1;
			end else if (len_q == LW'(9) && c5_q == 8'h42 && c6_q == 8'h4f && c7_q == 8'h54
					&& c8_q == 8'h48) begin
				f_mode = 2'd2; f_setm = 1'b1;
			end
			if (f_setm) f_st = (f_mode != 2'd2 && mode_q == f_mode) ? StSame : StMode;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q      <= S_IDLE;
			res_valid <= 1'b0;
			mode_q    <= 2'd0;
			rtu_q     <= 6'd48;
			idx_q     <= '0;
			rvalid_q  <= 1'b0;
		end else begin
			res_valid <= 1'b0;
			case (st_q)
				S_IDLE: if (job_valid) begin
					if (job.eval) begin
						st_q <= S_RUN; idx_q <= '0; rvalid_q <= 1'b0;
					end else begin
						res_valid <= 1'b1;
					end
				end
				S_RUN: begin
					rvalid_q <= idx_q < len_q;
					if (idx_q < len_q) idx_q <= idx_q + 1'b1;
					if (!(idx_q < len_q) && !rvalid_q) st_q <= S_DONE;
				end
				S_DONE: begin
					res_valid <= 1'b1;
					st_q <= S_IDLE;
					if (f_setm) mode_q <= f_mode;
					if (f_setr) rtu_q <= c4_q[5:0];
				end
				default: st_q <= S_IDLE;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (st_q == S_IDLE && job_valid) begin
			res_kind <= job.kind; res_echo <= job.echo;
			res_status <= StNone; res_target <= TgtIp; res_value <= '0;
			len_q <= eval_len;
			{ip_q, sub_q, mac_q, gate_q, rtu_q2, mode_q2} <= '1;
			dok_q <= '1; dig_q <= '0; hexok_q <= 1'b1; hex_q <= '0;
			for (int k = 0; k < 3; k++) begin
				dots_q[k] <= '0; oct_q[k] <= '0; acc_q[k] <= '0;
			end
		end else if (st_q == S_RUN && rvalid_q) begin
			if (pos == 0) c0_q <= rd_data;
			if (pos == 4) c4_q <= rd_data;
			if (pos == 5) c5_q <= rd_data;
			if (pos == 6) c6_q <= rd_data;
			if (pos == 7) c7_q <= rd_data;
			if (pos == 8) c8_q <= rd_data;
			if (!pfx_ok(0, 3, pos, rd_data)) ip_q <= 1'b0;
			if (!pfx_ok(1, 4, pos, rd_data)) sub_q <= 1'b0;
			if (!pfx_ok(2, 4, pos, rd_data)) mac_q <= 1'b0;
			if (!pfx_ok(3, 5, pos, rd_data)) gate_q <= 1'b0;
			if (!pfx_ok(4, 4, pos, rd_data)) rtu_q2 <= 1'b0;
			if (!pfx_ok(5, 5, pos, rd_data)) mode_q2 <= 1'b0;
			if (pos >= LW'(4) && pos < LW'(16)) begin
				if (is_digit(rd_data) || (rd_data >= 8'h41 && rd_data <= 8'h46))
					hex_q <= {hex_q[43:0], nib};
				else hexok_q <= 1'b0;
			end
			for (int k = 0; k < 3; k++) begin
				if (pos >= LW'(k + 3)) begin
					if (rd_data == 8'h2e) begin
						if (!dig_q[k] || dots_q[k] == 2'd3 || oct_q[k][8]) dok_q[k] <= 1'b0;
						else begin
							acc_q[k] <= {acc_q[k][23:0], oct_q[k][7:0]};
							dots_q[k] <= dots_q[k] + 1'b1;
							dig_q[k] <= 1'b0; oct_q[k] <= '0;
						end
					end else if (is_digit(rd_data)) begin
						dig_q[k] <= 1'b1;
						// Saturate at 256: anything above 255 is simply "too big".
						if (!oct_q[k][8]) begin
							if (({oct_q[k], 3'b0} + {2'b0, oct_q[k], 1'b0}
									+ {8'd0, rd_data[3:0]}) > 12'd255)
								oct_q[k] <= 9'h100;
							else
								oct_q[k] <= 9'(oct_q[k] * 4'd10 + rd_data[3:0]);
						end
					end else dok_q[k] <= 1'b0;
				end
			end
		end else if (st_q == S_DONE) begin
			res_status <= f_st; res_target <= f_tg; res_value <= f_val;
		end
	end

`ifndef SYNTH
	a_done: assert property (@(posedge clk) disable iff (!arst_n)
		st_q == S_DONE |=> res_valid) else $error("no result after evaluation");
	a_mode: assert property (@(posedge clk) disable iff (!arst_n) mode_q != 2'd3)
		else $error("bad mode");
	a_busy: assert property (@(posedge clk) disable iff (!arst_n)
		busy |-> !res_valid) else $error("result during walk");
`endif
endmodule

[rtl/uccp_outq.sv]
// Result queue: two entries, decouples the evaluator from the consumer.
module uccp_outq #(
	parameter int W = 71
) (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         wr,
	input  logic [W-1:0] wdata,
	input  logic         pop,
	output logic         empty,
	output logic         full,
	output logic [W-1:0] rdata
);
	logic [W-1:0] d_q [2];
	logic         rp_q, wp_q;
	logic [1:0]   cnt_q;
	logic         rd;

	assign empty = cnt_q == 2'd0;
	assign full  = cnt_q == 2'd2;
	assign rdata = d_q[rp_q];
	assign rd    = pop && !empty;

	always_ff @(posedge clk) if (wr) d_q[wp_q] <= wdata;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rp_q <= 1'b0; wp_q <= 1'b0; cnt_q <= '0;
		end else begin
			if (wr) wp_q <= ~wp_q;
			if (rd) rp_q <= ~rp_q;
			cnt_q <= cnt_q + {1'b0, wr} - {1'b0, rd};
		end
	end

`ifndef SYNTH
	a_ovf: assert property (@(posedge clk) disable iff (!arst_n) !(wr && full))
		else $error("queue overflow");
`endif
endmodule

[rtl/uart_config_command_parser.sv]
// Terminal configuration command parser.
// Input channel: rx_byte is taken when push is high and full is low. Each byte
// yields exactly one result on the result queue (empty/pop), holding the echo
// request, the command status, any parsed address and the current mode and
// unit digit.
// Plain bytes (echo, erase, ignored) pass from push through the job register
// and the result register to a result waiting. An enter byte on a non-empty
// line starts a walk of the stored line, one character a cycle from the line
// memory; full stays high during the walk.
// The result queue holds two results; when the receiver stops popping, full
// rises once the queue could overflow, so nothing is lost.
// Configuration: cfg_valid/cfg_ready write backspace_code (index 0) or
// enter_code (index 1); other indexes are ignored. ready is always high.
// Reset clears the line length, sets mode UDP and unit digit '0',
// backspace 8, enter 13, and empties the queue; the block is ready at once.
module uart_config_command_parser #(
	parameter int LINE_MAX = uccp_pkg::LineMaxDef
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        push,
	output logic        full,
	input  logic [7:0]  rx_byte,
	output logic        empty,
	input  logic        pop,
	output logic [1:0]  echo_kind,
	output logic [7:0]  echo_char,
	output logic [2:0]  cmd_status,
	output logic [1:0]  addr_target,
	output logic [47:0] addr_value,
	output logic [1:0]  mode_now,
	output logic [5:0]  rtu_now,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [0:0]  cfg_index,
	input  logic [7:0]  cfg_data
);
	import uccp_pkg::*;
	localparam int LW = $clog2(LINE_MAX + 1);
	localparam int AW = $clog2(LINE_MAX);
	localparam int QW = 71;

	logic [7:0]    bs_q, en_q;
	logic          acc, busy, job_valid, res_valid, qfull, qempty;
	job_t          job;
	logic [LW-1:0] eval_len;
	logic [AW-1:0] rd_addr;
	logic [7:0]    rd_data;
	logic [1:0]    r_kind, r_tgt, m_q;
	logic [7:0]    r_echo;
	logic [2:0]    r_st;
	logic [47:0]   r_val;
	logic [5:0]    u_q;
	logic [QW-1:0] qout;
	logic [1:0]    cnt_q;

	assign cfg_ready = 1'b1;
	// Count of items in flight in front/evaluator, plus queue, bounds admission.
	// A result that is about to enter the queue also holds admission off, so a
	// new request is taken only when the queue has room for its result.
	assign full = busy || job_valid || res_valid || qfull || (cnt_q != 2'd0);
	assign acc  = push && !full;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bs_q <= 8'd8; en_q <= 8'd13; cnt_q <= '0;
		end else begin
			if (cfg_valid && cfg_index == RegBackspace) bs_q <= cfg_data;
			if (cfg_valid && cfg_index == RegEnter) en_q <= cfg_data;
			// Hold admission off while a job enters the evaluator.
			cnt_q <= {1'b0, job_valid};
		end
	end

	uccp_front #(.LINE_MAX(LINE_MAX)) u_front (
		.clk, .arst_n, .in_valid(acc), .in_byte(rx_byte), .bs_code(bs_q), .en_code(en_q),
		.busy, .job_valid, .job, .eval_len, .rd_addr, .rd_data
	);

	uccp_eval #(.LINE_MAX(LINE_MAX)) u_eval (
		.clk, .arst_n, .job_valid, .job, .eval_len, .rd_addr, .rd_data, .busy,
		.res_valid, .res_kind(r_kind), .res_echo(r_echo), .res_status(r_st),
		.res_target(r_tgt), .res_value(r_val), .mode_q(m_q), .rtu_q(u_q)
	);

	// The result fields, the mode and the digit are registered together with
	// res_valid, so the queue captures them in the cycle res_valid is high.
	uccp_outq #(.W(QW)) u_outq (
		.clk, .arst_n, .wr(res_valid),
		.wdata({r_kind, r_echo, r_st, r_tgt, r_val, m_q, u_q}),
		.pop, .empty(qempty), .full(qfull), .rdata(qout)
	);

	assign empty = qempty;
	assign {echo_kind, echo_char, cmd_status, addr_target, addr_value, mode_now, rtu_now} = qout;

`ifndef SYNTH
	a_one: assert property (@(posedge clk) disable iff (!arst_n)
		acc |=> !acc) else $error("back to back admission");
	a_cfg: assert property (@(posedge clk) disable iff (!arst_n)
		$past(cfg_valid) && $past(cfg_index) == RegEnter |-> en_q == $past(cfg_data))
		else $error("enter code not written");
	a_fullq: assert property (@(posedge clk) disable iff (!arst_n)
		qfull |-> full) else $error("full not shown");
`endif
endmodule
